FILE: rtl/core/dqdm_pkg.sv
// Shared types, constants and helpers for the depth quad discontinuity mask
`timescale 1ns / 1ps

package dqdm_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int DEPTH_BITS_DEF = 16;

  // fixed register and field widths
  localparam int LW_BITS       = 12;
  localparam int THR_BITS      = 16;
  localparam int ROW_BITS      = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [ROW_BITS-1:0] RowMax       = '1;
  localparam logic [LW_BITS-1:0]  LineWidthRst = 12'd640;
  localparam logic [THR_BITS-1:0] ThresholdRst = 16'd50;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LINE_WIDTH      = 2'd0,
    REG_DEPTH_THRESHOLD = 2'd1,
    REG_FILLED_MODE     = 2'd2
  } reg_index_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [LW_BITS-1:0]  line_width;
    logic [THR_BITS-1:0] depth_threshold;
    logic                filled_mode;
  } cfg_t;

  // saturating row increment
  function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
    return (r == RowMax) ? r : r + ROW_BITS'(1);
  endfunction

endpackage

FILE: rtl/core/dqdm_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module dqdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/dqdm_pos.sv
// Raster position tracker: column and saturating row of each accepted sample
`timescale 1ns / 1ps

module dqdm_pos import dqdm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         frame_start,
  input  logic [LW_BITS-1:0]           line_width,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [ROW_BITS-1:0]          row
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = ((WID_W > LW_BITS) ? WID_W : LW_BITS) + 1;

  logic [COL_W-1:0]    column_count, column_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic [CMP_W-1:0]    lw_ext, active_w, col_inc;
  logic                wrap_pre, wrap_post;

  // clamp the configured width to the supported range
  always_comb begin
    lw_ext = CMP_W'(line_width);
    if (lw_ext < CMP_W'(2)) begin
      active_w = CMP_W'(2);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      active_w = CMP_W'(MAX_WIDTH);
    end else begin
      active_w = lw_ext;
    end
  end

  // position of the incoming sample, and the position after it
  always_comb begin
    wrap_pre = CMP_W'(column_count) >= active_w;
    if (frame_start) begin
      col = '0;
      row = '0;
    end else if (wrap_pre) begin
      col = '0;
      row = row_inc(row_count);
    end else begin
      col = column_count;
      row = row_count;
    end
    col_inc   = CMP_W'(col) + CMP_W'(1);
    wrap_post = col_inc >= active_w;
    if (wrap_post) begin
      column_count_next = '0;
      row_count_next    = row_inc(row);
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

FILE: rtl/core/dqdm_quad_check.sv
// Keep if filled: off row/column 0, corners nonzero, edge differences under threshold; if point: sample nonzero
`timescale 1ns / 1ps

module dqdm_quad_check import dqdm_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  cfg_t                  cfg,
  input  logic [DEPTH_BITS-1:0] upper_left,
  input  logic [DEPTH_BITS-1:0] upper,
  input  logic [DEPTH_BITS-1:0] left,
  input  logic [DEPTH_BITS-1:0] current,
  input  logic                  first_col,
  input  logic                  first_row,
  output logic                  keep
);

  localparam int TW = (DEPTH_BITS > THR_BITS) ? DEPTH_BITS : THR_BITS;

  logic edge_top, edge_left, edge_right, edge_bottom, all_nonzero;

  function automatic logic close_enough(input logic [DEPTH_BITS-1:0] p,
                                        input logic [DEPTH_BITS-1:0] q,
                                        input logic [THR_BITS-1:0]   thr);
    logic [DEPTH_BITS-1:0] diff;
    diff = (p > q) ? (p - q) : (q - p);
    return TW'(diff) < TW'(thr);
  endfunction

  // top, left, right and bottom edge tests run side by side
  assign edge_top    = close_enough(upper_left, upper, cfg.depth_threshold);
  assign edge_left   = close_enough(upper_left, left, cfg.depth_threshold);
  assign edge_right  = close_enough(upper, current, cfg.depth_threshold);
  assign edge_bottom = close_enough(left, current, cfg.depth_threshold);
  assign all_nonzero = (upper_left != '0) && (upper != '0) && (left != '0)
                       && (current != '0);

  // point mode only looks at the current sample
  always_comb begin
    if (cfg.filled_mode) begin
      keep = !first_col && !first_row && all_nonzero
             && edge_top && edge_left && edge_right && edge_bottom;
    end else begin
      keep = current != '0;
    end
  end

endmodule

FILE: rtl/core/depth_quad_discontinuity_mask_top.sv
// Top level of the depth quad discontinuity mask
`timescale 1ns / 1ps

// Depth samples enter in raster order on the input channel (in_valid/in_ready,
// fields depth and frame_start); each sample gives exactly one transaction on
// the output channel (out_valid/out_ready, fields keep, pixel_column,
// pixel_row). frame_start restarts the position at row 0, column 0.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data):
// index 0 line_width, 1 depth_threshold, 2 filled_mode; write only when idle.
// The accepting edge loads the sample and the line buffer read into the line
// buffer stage; when that stage advances, the quad test is loaded into the
// output register, which raises out_valid. Throughput is one sample per
// cycle while the receiver does not stall, set by the single read and single
// write of the line buffer RAM in each cycle.
// When the receiver stalls, the output register holds its result and the
// line buffer stage holds one more sample; input stalls after that.
// Reset clears the position, the neighbor registers and the pipeline, and
// loads the register defaults (width 640, threshold 50, filled mode). The
// line buffer is not cleared; rows below the first never read unwritten data.
module depth_quad_discontinuity_mask_top import dqdm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [DEPTH_BITS-1:0]        depth,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         keep,
  output logic [$clog2(MAX_WIDTH)-1:0] pixel_column,
  output logic [ROW_BITS-1:0]          pixel_row
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  cfg_t                  cfg;
  logic                  accept, s1_adv;
  logic [COL_W-1:0]      in_col;
  logic [ROW_BITS-1:0]   in_row;
  logic                  s1_valid, s1_fs;
  logic [DEPTH_BITS-1:0] s1_depth;
  logic [COL_W-1:0]      s1_col;
  logic [ROW_BITS-1:0]   s1_row;
  logic [DEPTH_BITS-1:0] above, left_depth, upper_left_depth;
  logic [DEPTH_BITS-1:0] quad_a, quad_c;
  logic                  keep_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width      <= LineWidthRst;
      cfg.depth_threshold <= ThresholdRst;
      cfg.filled_mode     <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_LINE_WIDTH:      cfg.line_width      <= cfg_data[LW_BITS-1:0];
        REG_DEPTH_THRESHOLD: cfg.depth_threshold <= cfg_data[THR_BITS-1:0];
        REG_FILLED_MODE:     cfg.filled_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake between input, line buffer stage and output register
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  dqdm_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .frame_start (frame_start),
    .line_width  (cfg.line_width),
    .col         (in_col),
    .row         (in_row)
  );

  // line buffer: read the sample above and overwrite it in the same cycle
  dqdm_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (in_col),
    .wdata (depth),
    .re    (accept),
    .raddr (in_col),
    .rdata (above)
  );

  // line buffer stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_depth <= depth;
      s1_col   <= in_col;
      s1_row   <= in_row;
      s1_fs    <= frame_start;
    end
  end

  // left and upper-left neighbors follow the sample leaving the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_depth       <= '0;
      upper_left_depth <= '0;
    end else if (s1_adv) begin
      left_depth       <= s1_depth;
      upper_left_depth <= above;
    end
  end

  assign quad_a = s1_fs ? '0 : upper_left_depth;
  assign quad_c = s1_fs ? '0 : left_depth;

  dqdm_quad_check #(.DEPTH_BITS(DEPTH_BITS)) u_check (
    .cfg        (cfg),
    .upper_left (quad_a),
    .upper      (above),
    .left       (quad_c),
    .current    (s1_depth),
    .first_col  (s1_col == '0),
    .first_row  (s1_row == '0),
    .keep       (keep_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      keep         <= keep_next;
      pixel_column <= s1_col;
      pixel_row    <= s1_row;
    end
  end

`ifndef SYNTHESIS
  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // in filled mode a kept quad never sits on the first row or first column
  a_quad_not_on_border: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep && cfg.filled_mode) |-> (pixel_column != '0 && pixel_row != '0))
    else $error("quad kept on frame border");

  // line buffer read data holds while its sample waits
  a_above_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(above)))
    else $error("line buffer data changed under a stalled sample");

  // frame start restarts the position
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_start) |=> (s1_valid && s1_col == '0 && s1_row == '0))
    else $error("frame start did not restart the position");
`endif

endmodule
